[rtl/mptt_pkg.sv]
// Package: types, codes and constants of the multi-port timeout timer bank.
`timescale 1ns / 1ps
package mptt_pkg;

    localparam int DEF_NUM_PORTS  = 4;
    localparam int DEF_NUM_TIMERS = 35;

    localparam int CFG_NUM = 8;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 6;

    localparam logic [30:0] FAR_LIMIT = 31'h7FFF_FFFF;
    localparam logic [31:0] NONE_US   = 32'hFFFF_FFFF;

    localparam logic [CFG_DW-1:0] CFG_RESET [CFG_NUM] = '{
        6'd0, 6'd1, 6'd2, 6'd21, 6'd22, 6'd26, 6'd27, 6'd34
    };

    typedef enum logic [2:0] {
        KIND_INIT      = 3'd0,
        KIND_ENABLE    = 3'd1,
        KIND_DISABLE   = 3'd2,
        KIND_DIS_RANGE = 3'd3,
        KIND_IS_DIS    = 3'd4,
        KIND_IS_EXP    = 3'd5,
        KIND_MANAGE    = 3'd6,
        KIND_NEXT      = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  port;
        logic [5:0]  timer;
        logic [2:0]  range_group;
        logic [31:0] duration_us;
        logic [63:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] next_us;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic enable;
        logic disable_one;
        logic query;
        logic read_one;
        logic scan_setup;
        logic scan_step;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        t_kind kind;
        logic  port_ok;
        logic  timer_ok;
        logic  scan_empty;
        logic  scan_last;
    } t_dp_status;

endpackage

[rtl/mptt_ctrl.sv]
// Controller: sequences one transfer through decode, scan and result phases.
`timescale 1ns / 1ps
module mptt_ctrl
    import mptt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_status.port_ok) begin
                    n_state = ST_DONE;
                end else begin
                    unique case (i_status.kind)
                        KIND_INIT, KIND_MANAGE, KIND_NEXT: n_state = ST_SCAN;
                        KIND_DIS_RANGE: begin
                            n_state = i_status.scan_empty ? ST_DONE : ST_SCAN;
                        end
                        KIND_IS_EXP: begin
                            n_state = i_status.timer_ok ? ST_WAIT : ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: o_cmd.load = i_start;
            ST_DECODE: begin
                if (i_status.port_ok) begin
                    unique case (i_status.kind)
                        KIND_INIT, KIND_MANAGE, KIND_NEXT: o_cmd.scan_setup = 1'b1;
                        KIND_DIS_RANGE: o_cmd.scan_setup = !i_status.scan_empty;
                        KIND_ENABLE:    o_cmd.enable = i_status.timer_ok;
                        KIND_DISABLE:   o_cmd.disable_one = i_status.timer_ok;
                        KIND_IS_DIS:    o_cmd.query = i_status.timer_ok;
                        KIND_IS_EXP:    o_cmd.read_one = i_status.timer_ok;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: o_cmd.scan_step = 1'b1;
            ST_DONE: o_cmd.emit = 1'b1;
            default: ;
        endcase
    end

endmodule

[rtl/mptt_dp.sv]
// Datapath: timer state bits, deadline memory, scan counter and result registers.
`timescale 1ns / 1ps
module mptt_dp
    import mptt_pkg::*;
#(
    parameter int NUM_PORTS  = DEF_NUM_PORTS,
    parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_item,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    output t_out_item         o_result,
    output logic              o_done
);

    localparam int DEPTH = NUM_PORTS * NUM_TIMERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [6:0] NT7      = 7'(NUM_TIMERS);
    localparam logic [6:0] NT7_LAST = 7'(NUM_TIMERS - 1);

    logic [CFG_DW-1:0] r_cfg [CFG_NUM];
    t_in_item          r_item;
    logic [AW-1:0]     r_base;
    logic [DEPTH-1:0]  r_active;
    logic [DEPTH-1:0]  r_disabled;
    logic [DEPTH-1:0]  n_active;
    logic [DEPTH-1:0]  n_disabled;
    logic [63:0]       mem [DEPTH];
    logic [63:0]       r_rd_data;
    logic              r_pipe_valid;
    logic [AW-1:0]     r_pipe_addr;
    logic [TW-1:0]     r_idx;
    logic [TW-1:0]     r_end;
    logic              r_flag;
    logic              n_flag;
    logic [30:0]       r_best;
    logic [30:0]       n_best;
    t_out_item         r_result;
    logic              r_done;

    logic          port_ok;
    logic          timer_ok;
    logic          grp_ok;
    logic [1:0]    grp;
    logic [6:0]    first7;
    logic [6:0]    last7;
    logic [AW-1:0] single_addr;
    logic [AW-1:0] scan_addr;
    logic [AW-1:0] rd_addr;
    logic          due;
    logic [63:0]   diff;
    logic [30:0]   delta;
    t_kind         kind;

    assign kind     = t_kind'(r_item.kind);
    assign port_ok  = {2'b00, r_item.port} < 4'(NUM_PORTS);
    assign timer_ok = {1'b0, r_item.timer} < NT7;
    assign grp_ok   = !r_item.range_group[2];
    assign grp      = r_item.range_group[1:0];
    assign first7   = {1'b0, r_cfg[{grp, 1'b0}]};
    assign last7    = ({1'b0, r_cfg[{grp, 1'b1}]} >= NT7) ? NT7_LAST
                                                            : {1'b0, r_cfg[{grp, 1'b1}]};

    assign single_addr = r_base + AW'(r_item.timer[TW-1:0]);
    assign scan_addr   = r_base + AW'(r_idx);
    assign rd_addr     = i_cmd.read_one ? single_addr : scan_addr;

    assign o_status.kind       = kind;
    assign o_status.port_ok    = port_ok;
    assign o_status.timer_ok   = timer_ok;
    assign o_status.scan_empty = !grp_ok || (first7 > last7);
    assign o_status.scan_last  = (r_idx == r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_base <= AW'(i_item.port) * AW'(NUM_TIMERS);
        end
        if (i_cmd.scan_setup) begin
            if (kind == KIND_DIS_RANGE) begin
                r_idx <= first7[TW-1:0];
                r_end <= last7[TW-1:0];
            end else begin
                r_idx <= '0;
                r_end <= NT7_LAST[TW-1:0];
            end
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // deadline memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.enable) begin
            mem[single_addr] <= r_item.now_us + 64'(r_item.duration_us);
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_valid <= 1'b0;
        end else begin
            r_pipe_valid <= i_cmd.read_one ||
                            (i_cmd.scan_step &&
                             (kind == KIND_MANAGE || kind == KIND_NEXT));
        end
        r_pipe_addr <= rd_addr;
    end

    assign due   = r_item.now_us >= r_rd_data;
    assign diff  = r_rd_data - r_item.now_us;
    assign delta = due ? 31'd0 : ((diff[63:31] != '0) ? FAR_LIMIT : diff[30:0]);

    always_comb begin
        n_active   = r_active;
        n_disabled = r_disabled;
        n_flag     = r_flag;
        n_best     = r_best;
        if (i_cmd.load) begin
            n_flag = 1'b0;
            n_best = FAR_LIMIT;
        end
        if (i_cmd.enable) begin
            n_active[single_addr]   = 1'b1;
            n_disabled[single_addr] = 1'b0;
        end
        if (i_cmd.disable_one) begin
            n_active[single_addr]   = 1'b0;
            n_disabled[single_addr] = 1'b1;
        end
        if (i_cmd.query) begin
            n_flag = r_disabled[single_addr];
        end
        if (i_cmd.scan_step && (kind == KIND_INIT || kind == KIND_DIS_RANGE)) begin
            n_active[scan_addr]   = 1'b0;
            n_disabled[scan_addr] = 1'b1;
        end
        if (r_pipe_valid) begin
            if (r_active[r_pipe_addr]) begin
                if (kind == KIND_NEXT) begin
                    if (delta < r_best) begin
                        n_best = delta;
                    end
                end else if (due) begin
                    n_active[r_pipe_addr]   = 1'b0;
                    n_disabled[r_pipe_addr] = 1'b0;
                    n_flag = 1'b1;
                end
            end else begin
                n_flag = !r_disabled[r_pipe_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_disabled <= '1;
        end else begin
            r_active   <= n_active;
            r_disabled <= n_disabled;
        end
        r_flag <= n_flag;
        r_best <= n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_result.flag <= port_ok && r_flag &&
                             (kind == KIND_IS_DIS || kind == KIND_IS_EXP);
            if (kind != KIND_NEXT) begin
                r_result.next_us <= '0;
            end else if (!port_ok || r_best == FAR_LIMIT) begin
                r_result.next_us <= NONE_US;
            end else begin
                r_result.next_us <= {1'b0, r_best};
            end
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

[rtl/multi_port_timeout_timer_bank.sv]
// Top level: multi-port timeout timer bank, controller plus datapath.
// Single-timer operations finish from decode; the expired query adds a deadline memory read,
// and init, range disable, manage and next-expiration walk the timers, one timer per cycle;
// an empty range or a bad port skips the walk.
// Busy drops in the strobe cycle; a new transfer is taken only while busy is low.
// Synchronous active-low reset: all timers disabled, group registers to defaults.
`timescale 1ns / 1ps
module multi_port_timeout_timer_bank
    import mptt_pkg::*;
#(
    parameter int NUM_PORTS  = DEF_NUM_PORTS,
    parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in_item          i_item,
    output logic              o_busy,
    output t_out_item         o_result,
    output logic              o_done,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       ctrl_start;

    assign ctrl_start = i_start;

    mptt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ctrl_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    mptt_dp #(
        .NUM_PORTS  (NUM_PORTS),
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("controller issued overlapping commands");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after input transfer");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> (o_done && !o_busy))
        else $error("result not presented after emit");

endmodule

[dv/mptt_checker.sv]
// Checker: watches the item, result and register channels, predicts the bank and compares.
`timescale 1ns / 1ps
module mptt_checker
    import mptt_pkg::*;
#(
    parameter int NUM_PORTS  = DEF_NUM_PORTS,
    parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in_item          i_item,
    input  logic              i_busy,
    input  t_out_item         i_result,
    input  logic              i_done,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output int                o_fail_count
);

    localparam int NUM_GROUPS = CFG_NUM / 2;

    logic [CFG_DW-1:0]     group_bounds [CFG_NUM];
    bit [NUM_TIMERS-1:0]   armed        [NUM_PORTS];
    bit [NUM_TIMERS-1:0]   parked       [NUM_PORTS];
    bit [63:0]             deadline     [NUM_PORTS][NUM_TIMERS];
    t_out_item             pending_results [$];
    int                    fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void reset_bank();
        for (int p = 0; p < NUM_PORTS; p++) begin
            armed[p]  = '0;
            parked[p] = '1;
        end
        for (int r = 0; r < CFG_NUM; r++) begin
            group_bounds[r] = CFG_RESET[r];
        end
    endfunction

    // Applies one transfer to the bank copy and returns the response it causes.
    function automatic t_out_item bank_response(t_in_item it);
        t_out_item res;
        t_kind     kind;
        int        p;
        int        t;
        int        g;
        int        first;
        int        last;
        bit        timer_ok;
        bit [63:0] best;
        bit [63:0] span;
        res      = '0;
        kind     = t_kind'(it.kind);
        p        = it.port;
        t        = it.timer;
        g        = it.range_group;
        timer_ok = (t < NUM_TIMERS);
        if (p >= NUM_PORTS) begin
            if (kind == KIND_NEXT) res.next_us = NONE_US;
            return res;
        end
        case (kind)
            KIND_INIT: begin
                armed[p]  = '0;
                parked[p] = '1;
            end
            KIND_ENABLE: if (timer_ok) begin
                armed[p][t]    = 1'b1;
                parked[p][t]   = 1'b0;
                deadline[p][t] = it.now_us + 64'(it.duration_us);
            end
            KIND_DISABLE: if (timer_ok) begin
                armed[p][t]  = 1'b0;
                parked[p][t] = 1'b1;
            end
            KIND_DIS_RANGE: if (g < NUM_GROUPS) begin
                first = group_bounds[2 * g];
                last  = group_bounds[2 * g + 1];
                if (last >= NUM_TIMERS) last = NUM_TIMERS - 1;
                for (int i = first; i <= last; i++) begin
                    armed[p][i]  = 1'b0;
                    parked[p][i] = 1'b1;
                end
            end
            KIND_IS_DIS: if (timer_ok) begin
                res.flag = parked[p][t];
            end
            KIND_IS_EXP: if (timer_ok) begin
                if (armed[p][t]) begin
                    if (it.now_us >= deadline[p][t]) begin
                        armed[p][t]  = 1'b0;
                        parked[p][t] = 1'b0;
                        res.flag     = 1'b1;
                    end
                end else begin
                    res.flag = !parked[p][t];
                end
            end
            KIND_MANAGE: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (armed[p][i] && it.now_us >= deadline[p][i]) begin
                        armed[p][i]  = 1'b0;
                        parked[p][i] = 1'b0;
                    end
                end
            end
            KIND_NEXT: begin
                best = 64'(FAR_LIMIT);
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (armed[p][i]) begin
                        span = (deadline[p][i] <= it.now_us) ? 64'd0
                                                             : deadline[p][i] - it.now_us;
                        if (span > 64'(FAR_LIMIT)) span = 64'(FAR_LIMIT);
                        if (span < best) best = span;
                    end
                end
                res.next_us = (best == 64'(FAR_LIMIT)) ? NONE_US : best[31:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item oldest;
        if (!i_rst_n) begin
            reset_bank();
            pending_results.delete();
        end else begin
            if (i_done) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: flag %0d, next_us %0d",
                           i_result.flag, i_result.next_us);
                    fail_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (i_result.flag !== oldest.flag) begin
                        $error("flag: expected %0d, got %0d", oldest.flag, i_result.flag);
                        fail_count++;
                    end
                    if (i_result.next_us !== oldest.next_us) begin
                        $error("next_us: expected %0d, got %0d",
                               oldest.next_us, i_result.next_us);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) group_bounds[i_cfg_idx] = i_cfg_data;
            if (i_start && !i_busy) pending_results.push_back(bank_response(i_item));
        end
    end

endmodule

[dv/tb_top.sv]
// Testbench top: clock, reset, stimulus and verdict for the timeout timer bank.
`timescale 1ns / 1ps
module tb_top;
    import mptt_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 48;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_GROUPS      = CFG_NUM / 2;

    localparam logic [2:0] GRP_DPM = 3'd0;
    localparam logic [2:0] GRP_PE  = 3'd1;
    localparam logic [2:0] GRP_BAD = 3'd7;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    t_in_item          item     = '0;
    logic              cfg_we   = 1'b0;
    logic [CFG_IW-1:0] cfg_idx  = '0;
    logic [CFG_DW-1:0] cfg_data = '0;
    logic              busy;
    logic              done;
    t_out_item         result;
    int                fail_count;

    int                n_sent = 0;
    int                n_done = 0;
    int                idle_cycles = 0;
    bit                no_idle = 1'b0;
    logic [63:0]       now_base = '0;
    logic [CFG_DW-1:0] cfg_plan [CFG_NUM];

    multi_port_timeout_timer_bank dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_item     (item),
        .o_busy     (busy),
        .o_result   (result),
        .o_done     (done),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mptt_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_item       (item),
        .i_busy       (busy),
        .i_result     (result),
        .i_done       (done),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) begin
        if (rst_n && done) n_done <= n_done + 1;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("multi_port_timeout_timer_bank verification failed");
                $finish;
            end
        end
    end

    function automatic t_in_item make_item(t_kind kind, int port, int timer,
                                           logic [2:0] grp, logic [31:0] dur,
                                           logic [63:0] now);
        t_in_item it;
        it.kind        = kind;
        it.port        = 2'(port);
        it.timer       = 6'(timer);
        it.range_group = grp;
        it.duration_us = dur;
        it.now_us      = now;
        return it;
    endfunction

    // Mostly a monotonic clock with short steps so deadlines come due; some jumps and noise.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned roll;
        it   = '0;
        roll = $urandom_range(0, 99);
        if (roll < 25)      it.kind = KIND_ENABLE;
        else if (roll < 40) it.kind = KIND_IS_EXP;
        else if (roll < 55) it.kind = KIND_NEXT;
        else if (roll < 65) it.kind = KIND_MANAGE;
        else if (roll < 75) it.kind = KIND_IS_DIS;
        else if (roll < 85) it.kind = KIND_DISABLE;
        else if (roll < 95) it.kind = KIND_DIS_RANGE;
        else                it.kind = KIND_INIT;
        it.port  = 2'($urandom_range(0, 3));
        it.timer = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(DEF_NUM_TIMERS, 63))
                                               : 6'($urandom_range(0, DEF_NUM_TIMERS - 1));
        it.range_group = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(NUM_GROUPS, 7))
                                                     : 3'($urandom_range(0, NUM_GROUPS - 1));
        roll = $urandom_range(0, 99);
        if (roll < 45)      it.duration_us = $urandom_range(0, 3000);
        else if (roll < 65) it.duration_us = $urandom_range(0, 1 << 20);
        else if (roll < 80) it.duration_us = 32'h7FFF_FFF0 + $urandom_range(0, 32);
        else                it.duration_us = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            it.now_us = {$urandom, $urandom};
        end else begin
            if (roll < 9) now_base += {$urandom_range(0, 7), $urandom};
            else          now_base += $urandom_range(0, 400);
            it.now_us = now_base;
        end
        return it;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        if (roll < 97) return $urandom_range(5, 45);
        return $urandom_range(46, 150);
    endfunction

    task automatic send_item(input t_in_item it);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (n_done < n_sent) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_cfg_plan();
        for (int r = 0; r < CFG_NUM; r++) begin
            @(negedge clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IW'(r);
            cfg_data <= cfg_plan[r];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase();
        int unsigned roll;
        roll = $urandom_range(0, 2);
        if (roll == 0)      now_base = 64'($urandom_range(0, 100000));
        else if (roll == 1) now_base = {$urandom, $urandom};
        else                now_base = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 200000);
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_item(random_item());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(make_item(KIND_NEXT,      0,  0, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_IS_DIS,    0,  0, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_IS_EXP,    0,  0, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_ENABLE,    0,  0, GRP_DPM, 32'd0, 64'd5000));
        send_item(make_item(KIND_IS_DIS,    0,  0, GRP_DPM, 32'd0, 64'd5000));
        send_item(make_item(KIND_NEXT,      0,  0, GRP_DPM, 32'd0, 64'd5000));
        send_item(make_item(KIND_IS_EXP,    0,  0, GRP_DPM, 32'd0, 64'd4999));
        send_item(make_item(KIND_IS_EXP,    0,  0, GRP_DPM, 32'd0, 64'd5000));
        send_item(make_item(KIND_IS_EXP,    0,  0, GRP_DPM, 32'd0, 64'd5000));
        send_item(make_item(KIND_ENABLE,    1, 34, GRP_DPM, '1, '1));
        send_item(make_item(KIND_NEXT,      1,  0, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_ENABLE,    1,  5, GRP_DPM, 32'h7FFF_FFFE, 64'd0));
        send_item(make_item(KIND_NEXT,      1,  0, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_DISABLE,   1,  5, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_ENABLE,    1,  6, GRP_DPM, 32'h7FFF_FFFF, 64'd0));
        send_item(make_item(KIND_NEXT,      1,  0, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_ENABLE,    2, 63, GRP_DPM, 32'd10, 64'd0));
        send_item(make_item(KIND_IS_DIS,    2, 63, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_IS_EXP,    2, 35, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_ENABLE,    2, 10, GRP_DPM, 32'd100, 64'd1000));
        send_item(make_item(KIND_MANAGE,    2,  0, GRP_DPM, 32'd0, 64'd1100));
        send_item(make_item(KIND_IS_EXP,    2, 10, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_ENABLE,    3,  3, GRP_DPM, 32'd50, 64'd0));
        send_item(make_item(KIND_DIS_RANGE, 3,  0, GRP_BAD, 32'd0, 64'd0));
        send_item(make_item(KIND_DIS_RANGE, 3,  0, GRP_PE,  32'd0, 64'd0));
        send_item(make_item(KIND_ENABLE,    3, 30, GRP_DPM, 32'd50, 64'd0));
        send_item(make_item(KIND_INIT,      3,  0, GRP_DPM, 32'd0, 64'd0));
        send_item(make_item(KIND_IS_DIS,    3, 30, GRP_DPM, 32'd0, 64'd0));
        random_phase();

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            drain();
            if (ph == 1) begin
                // full span past the bank, reversed, single timer, first beyond the bank
                cfg_plan = '{6'd0, 6'd63, 6'd63, 6'd0, 6'd34, 6'd34, 6'd63, 6'd63};
            end else begin
                for (int r = 0; r < CFG_NUM; r++) begin
                    cfg_plan[r] = ($urandom_range(0, 1) == 0)
                                  ? CFG_DW'($urandom_range(0, DEF_NUM_TIMERS - 1))
                                  : CFG_DW'($urandom_range(0, 63));
                end
            end
            write_cfg_plan();
            random_phase();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("multi_port_timeout_timer_bank verification clean");
        end else begin
            $display("multi_port_timeout_timer_bank verification failed");
        end
        $finish;
    end

endmodule
